### rtl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg: shared types and constants of the masked window correlator
// Beat layouts, control codes and fixed widths used across the block.
// ----------------------------------------------------------------------------
package mwc_pkg;

  // fixed sizes
  localparam int MAX_WINDOW = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 6;
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;
  localparam int PROD_W     = 32;
  localparam int SUM_X_W    = 22;
  localparam int SUM_XX_W   = 36;
  localparam int SUM_XY_W   = 37;
  localparam int POS_W      = 24;
  localparam int CORR_W     = 16;
  localparam int MS_W       = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_AW     = 1;
  localparam int WORK_DEPTH = 2;
  localparam int OUT_DEPTH  = 2;

  // reset values of the registers
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd10;
  localparam logic [MS_W-1:0]  MS_RESET  = 16'd1;
  localparam logic [POS_W-1:0] POS_MAX   = 24'hFFFFFF;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MIN_SPREAD  = 1'b1;

  // input beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic                       sample_valid;
    logic                       last_sample;
  } in_t;

  // result beat
  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic signed [CORR_W-1:0] correlation;
    logic [WIN_W-1:0]         valid_count;
    logic                     last_result;
  } out_t;

  // classified item: the pair plus its masked contributions to the sums
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       v;
    logic                       last;
    logic [SQ_W-1:0]            xx;
    logic [SQ_W-1:0]            yy;
    logic signed [PROD_W-1:0]   xy;
  } work_t;

  // one ring entry
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       v;
  } ring_t;

  // window statistics handed to the correlation unit
  typedef struct packed {
    logic [WIN_W-1:0]           n;
    logic signed [SUM_X_W-1:0]  sum_x;
    logic signed [SUM_X_W-1:0]  sum_y;
    logic [SUM_XX_W-1:0]        sum_xx;
    logic [SUM_XX_W-1:0]        sum_yy;
    logic signed [SUM_XY_W-1:0] sum_xy;
    logic [MS_W-1:0]            min_spread;
  } corr_in_t;

  // window engine states
  typedef enum logic [3:0] {
    B_IDLE, B_ADD, B_LOOP, B_CSTART, B_CWAIT, B_PUSH, B_POP, B_UPD, B_CLEAR
  } back_state_t;

  // correlation unit states
  typedef enum logic [2:0] {
    C_IDLE, C_MUL, C_DRAIN, C_POST, C_DONE
  } corr_state_t;

  // correlation unit multiply steps
  typedef enum logic [3:0] {
    OP_NXX, OP_SXX, OP_NYY, OP_SYY, OP_NXY, OP_SXSY, OP_P,
    OP_NN, OP_THR, OP_THR2, OP_RHS, OP_DSQ, OP_PD
  } corr_op_t;

endpackage

### rtl/mwc_ram.sv
// ----------------------------------------------------------------------------
// mwc_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mwc_fifo.sv
// ----------------------------------------------------------------------------
// mwc_fifo: small synchronous queue
// Push/full on the write side, pop/empty on the read side; head is shown
// directly on rdata.
// ----------------------------------------------------------------------------
module mwc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

### rtl/mwc_front.sv
// ----------------------------------------------------------------------------
// mwc_front: input side of the correlator
// Takes pair beats, works out their masked contributions to the running
// sums and queues them for the window engine.
// ----------------------------------------------------------------------------
module mwc_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  mwc_pkg::in_t  in_data,
  input  logic          w_pop,
  output logic          w_empty,
  output mwc_pkg::work_t w_data
);
  import mwc_pkg::*;

  logic signed [PROD_W-1:0] pxx, pyy, pxy;
  work_t                    cls;
  logic [$bits(work_t)-1:0] q_rd;

  // products of the pair; masked pairs contribute nothing
  assign pxx = in_data.sample_x * in_data.sample_x;
  assign pyy = in_data.sample_y * in_data.sample_y;
  assign pxy = in_data.sample_x * in_data.sample_y;

  always_comb begin
    cls.x    = in_data.sample_x;
    cls.y    = in_data.sample_y;
    cls.v    = in_data.sample_valid;
    cls.last = in_data.last_sample;
    cls.xx   = in_data.sample_valid ? pxx[SQ_W-1:0] : '0;
    cls.yy   = in_data.sample_valid ? pyy[SQ_W-1:0] : '0;
    cls.xy   = in_data.sample_valid ? pxy : '0;
  end

  mwc_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (DEPTH)
  ) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (cls),
    .pop   (w_pop),
    .empty (w_empty),
    .rdata (q_rd)
  );

  assign w_data = work_t'(q_rd);

endmodule

### rtl/mwc_corr.sv
// ----------------------------------------------------------------------------
// mwc_corr: Pearson correlation of one window
// Works through the covariance terms, the spread test and a bit-by-bit
// search for the Q1.14 coefficient on one shared 32x32 multiplier, with
// wider products built from limbs and summed in an accumulator.
// ----------------------------------------------------------------------------
module mwc_corr (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  mwc_pkg::corr_in_t                cin,
  output logic                             done,
  output logic signed [mwc_pkg::CORR_W-1:0] result
);
  import mwc_pkg::*;

  localparam logic [14:0] CAND_TOP   = 15'd16384;
  localparam logic [3:0]  SEARCH_TOP = 4'd14;
  localparam logic [15:0] D_TOP      = 16'd32767;

  // operands of one multiply step, split in 32-bit limbs
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [1:0][31:0] b;
    logic [1:0]       la;
    logic             lb;
  } mload_t;

  function automatic mload_t mload(input logic [95:0] a, input logic [63:0] b,
                                   input logic [1:0] la, input logic lb);
    mload_t m;
    m.a  = a;
    m.b  = b;
    m.la = la;
    m.lb = lb;
    return m;
  endfunction

  corr_state_t st_r, st_nxt;
  corr_op_t    op_r;
  mload_t      ml_r;
  logic [1:0]  i_r;
  logic        j_r;
  logic [63:0] prod_r;
  logic [1:0]  psh_r;
  logic        pv_r;
  logic [127:0] acc_r;

  logic [WIN_W-1:0] n_r;
  logic [MS_W-1:0]  ms_r;
  logic [20:0]      sxm_r, sym_r;
  logic             sxs_r, sys_r, sxys_r;
  logic [35:0]      sxx_r, syy_r, sxym_r;
  logic [41:0]      t_r, ac_r;
  logic [40:0]      dx_r, dy_r;
  logic             sc_r;
  logic [80:0]      p_r;
  logic [84:0]      rhs_r;
  logic [14:0]      m_r, cand_r;
  logic [3:0]       bit_r;
  logic signed [CORR_W-1:0] res_r;

  logic [31:0]  a_limb, b_limb;
  logic         last_pair;
  logic [127:0] acc_add;
  logic [SUM_X_W-1:0]  sx_abs, sy_abs;
  logic [SUM_XY_W-1:0] sxy_abs;
  logic [42:0]  dsub;
  logic [40:0]  dclamp;
  logic signed [43:0] term1, term2, cval;
  logic [43:0]  cneg;
  logic         thr_fail, le, pd_fin;
  logic [14:0]  m_new, cand_nx;
  logic [3:0]   bit_dn;
  logic [15:0]  d_nx;

  // limb selection and accumulator alignment
  assign a_limb    = ml_r.a[i_r];
  assign b_limb    = ml_r.b[j_r];
  assign last_pair = (i_r == ml_r.la) && (j_r == ml_r.lb);

  always_comb begin
    case (psh_r)
      2'd0:    acc_add = {64'b0, prod_r};
      2'd1:    acc_add = {32'b0, prod_r, 32'b0};
      2'd2:    acc_add = {prod_r, 64'b0};
      default: acc_add = {prod_r[31:0], 96'b0};
    endcase
  end

  // magnitudes of the signed sums
  assign sx_abs  = cin.sum_x[SUM_X_W-1] ? -cin.sum_x : cin.sum_x;
  assign sy_abs  = cin.sum_y[SUM_X_W-1] ? -cin.sum_y : cin.sum_y;
  assign sxy_abs = cin.sum_xy[SUM_XY_W-1] ? -cin.sum_xy : cin.sum_xy;

  // spread terms, clamped at zero
  assign dsub   = {1'b0, t_r} - {1'b0, acc_r[41:0]};
  assign dclamp = dsub[42] ? '0 : dsub[40:0];

  // covariance term from n*|Sxy| and |Sx|*|Sy| with their signs
  assign term1 = sxys_r ? -$signed({2'b0, t_r}) : $signed({2'b0, t_r});
  assign term2 = (sxs_r ^ sys_r) ? -$signed({2'b0, acc_r[41:0]})
                                 : $signed({2'b0, acc_r[41:0]});
  assign cval  = term1 - term2;
  assign cneg  = -cval;

  // spread test and search step
  assign thr_fail = ({47'b0, p_r} <= acc_r) || (ac_r == '0);
  assign le       = (acc_r <= {13'b0, rhs_r, 30'b0});
  assign m_new    = le ? cand_r : m_r;
  assign pd_fin   = (m_new == CAND_TOP) || (bit_r == '0);
  assign bit_dn   = bit_r - 1'b1;
  assign cand_nx  = m_new | (15'd1 << bit_dn);
  assign d_nx     = {cand_nx, 1'b0} - 16'd1;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      C_IDLE: begin
        if (start) begin
          st_nxt = (cin.n == '0) ? C_DONE : C_MUL;
        end
      end
      C_MUL: begin
        if (last_pair) begin
          st_nxt = C_DRAIN;
        end
      end
      C_DRAIN: st_nxt = C_POST;
      C_POST: begin
        if ((op_r == OP_THR2 && thr_fail) || (op_r == OP_PD && pd_fin)) begin
          st_nxt = C_DONE;
        end else begin
          st_nxt = C_MUL;
        end
      end
      C_DONE: st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  assign done   = (st_r == C_DONE);
  assign result = res_r;

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      C_IDLE: begin
        if (start) begin
          n_r    <= cin.n;
          ms_r   <= cin.min_spread;
          sxm_r  <= sx_abs[20:0];
          sym_r  <= sy_abs[20:0];
          sxs_r  <= cin.sum_x[SUM_X_W-1];
          sys_r  <= cin.sum_y[SUM_X_W-1];
          sxx_r  <= cin.sum_xx;
          syy_r  <= cin.sum_yy;
          sxym_r <= sxy_abs[35:0];
          sxys_r <= cin.sum_xy[SUM_XY_W-1];
          res_r  <= '0;
          op_r   <= OP_NXX;
          ml_r   <= mload({60'b0, cin.sum_xx}, {58'b0, cin.n}, 2'd1, 1'b0);
          i_r    <= '0;
          j_r    <= 1'b0;
          acc_r  <= '0;
          pv_r   <= 1'b0;
        end
      end
      C_MUL: begin
        prod_r <= a_limb * b_limb;
        psh_r  <= i_r + {1'b0, j_r};
        pv_r   <= 1'b1;
        if (pv_r) begin
          acc_r <= acc_r + acc_add;
        end
        if (j_r == ml_r.lb) begin
          j_r <= 1'b0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      C_DRAIN: begin
        if (pv_r) begin
          acc_r <= acc_r + acc_add;
        end
        pv_r <= 1'b0;
      end
      C_POST: begin
        i_r   <= '0;
        j_r   <= 1'b0;
        acc_r <= '0;
        case (op_r)
          OP_NXX: begin
            t_r  <= acc_r[41:0];
            op_r <= OP_SXX;
            ml_r <= mload({75'b0, sxm_r}, {43'b0, sxm_r}, 2'd0, 1'b0);
          end
          OP_SXX: begin
            dx_r <= dclamp;
            op_r <= OP_NYY;
            ml_r <= mload({60'b0, syy_r}, {58'b0, n_r}, 2'd1, 1'b0);
          end
          OP_NYY: begin
            t_r  <= acc_r[41:0];
            op_r <= OP_SYY;
            ml_r <= mload({75'b0, sym_r}, {43'b0, sym_r}, 2'd0, 1'b0);
          end
          OP_SYY: begin
            dy_r <= dclamp;
            op_r <= OP_NXY;
            ml_r <= mload({60'b0, sxym_r}, {58'b0, n_r}, 2'd1, 1'b0);
          end
          OP_NXY: begin
            t_r  <= acc_r[41:0];
            op_r <= OP_SXSY;
            ml_r <= mload({75'b0, sxm_r}, {43'b0, sym_r}, 2'd0, 1'b0);
          end
          OP_SXSY: begin
            ac_r <= cval[43] ? cneg[41:0] : cval[41:0];
            sc_r <= cval[43];
            op_r <= OP_P;
            ml_r <= mload({55'b0, dx_r}, {23'b0, dy_r}, 2'd1, 1'b1);
          end
          OP_P: begin
            p_r  <= acc_r[80:0];
            op_r <= OP_NN;
            ml_r <= mload({90'b0, n_r}, {58'b0, n_r}, 2'd0, 1'b0);
          end
          OP_NN: begin
            op_r <= OP_THR;
            ml_r <= mload({80'b0, ms_r}, {53'b0, acc_r[10:0]}, 2'd0, 1'b0);
          end
          OP_THR: begin
            op_r <= OP_THR2;
            ml_r <= mload({70'b0, acc_r[25:0]}, {38'b0, acc_r[25:0]}, 2'd0, 1'b0);
          end
          OP_THR2: begin
            op_r <= OP_RHS;
            ml_r <= mload({54'b0, ac_r}, {22'b0, ac_r}, 2'd1, 1'b1);
          end
          OP_RHS: begin
            rhs_r  <= acc_r[84:0];
            m_r    <= '0;
            bit_r  <= SEARCH_TOP;
            cand_r <= CAND_TOP;
            op_r   <= OP_DSQ;
            ml_r   <= mload({80'b0, D_TOP}, {48'b0, D_TOP}, 2'd0, 1'b0);
          end
          OP_DSQ: begin
            op_r <= OP_PD;
            ml_r <= mload({15'b0, p_r}, {34'b0, acc_r[29:0]}, 2'd2, 1'b0);
          end
          OP_PD: begin
            m_r <= m_new;
            if (pd_fin) begin
              res_r <= sc_r ? -$signed({1'b0, m_new}) : $signed({1'b0, m_new});
            end else begin
              bit_r  <= bit_dn;
              cand_r <= cand_nx;
              op_r   <= OP_DSQ;
              ml_r   <= mload({80'b0, d_nx}, {48'b0, d_nx}, 2'd0, 1'b0);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

### rtl/mwc_back.sv
// ----------------------------------------------------------------------------
// mwc_back: window engine
// Owns the pair ring and the running sums, decides which windows are
// complete, runs the correlation unit for each and retires the oldest pair.
// ----------------------------------------------------------------------------
module mwc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mwc_pkg::WIN_W-1:0]  win_size,
  input  logic [mwc_pkg::MS_W-1:0]   min_spread,
  input  logic                       w_empty,
  output logic                       w_pop,
  input  mwc_pkg::work_t             w_data,
  input  logic                       r_full,
  output logic                       r_push,
  output mwc_pkg::out_t              r_data
);
  import mwc_pkg::*;

  back_state_t st_r, st_nxt;
  work_t       item_r;
  logic        first_r, elast_r;
  logic signed [SUM_X_W-1:0]  sum_x_r, sum_y_r;
  logic [SUM_XX_W-1:0]        sum_xx_r, sum_yy_r;
  logic signed [SUM_XY_W-1:0] sum_xy_r;
  logic [WIN_W-1:0] n_r, fill_r, k_r;
  logic [PTR_W-1:0] head_r;
  logic [POS_W-1:0] pos_r;
  out_t             res_r;

  logic                     rv_r;
  logic signed [SAMPLE_W-1:0] rx_r, ry_r;
  logic [SQ_W-1:0]          rxx_r, ryy_r;
  logic signed [PROD_W-1:0] rxy_r;

  logic [WIN_W-1:0] weff;
  logic             emit_ok;
  ring_t            ring_wd, ring_rd;
  logic [$bits(ring_t)-1:0] ring_q;
  logic             ram_we;
  logic [PTR_W-1:0] tail;
  logic signed [PROD_W-1:0] qxx, qyy, qxy;
  corr_in_t         cin;
  logic             c_start, c_done;
  logic signed [CORR_W-1:0] c_res;

  // effective window length
  always_comb begin
    if (win_size == '0) begin
      weff = WIN_W'(1);
    end else if (win_size > WIN_W'(MAX_WINDOW)) begin
      weff = WIN_W'(MAX_WINDOW);
    end else begin
      weff = win_size;
    end
  end

  // another window is due for the current pair
  assign emit_ok = (k_r < WIN_W'(MAX_WINDOW)) &&
                   (item_r.last ? (fill_r != '0) : (fill_r >= weff));

  // ring of the last pairs
  assign tail    = head_r + fill_r[PTR_W-1:0];
  assign ring_wd = '{x: item_r.x, y: item_r.y, v: item_r.v};

  mwc_ram #(
    .WIDTH ($bits(ring_t)),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ring_wd),
    .raddr (head_r),
    .rdata (ring_q)
  );

  assign ring_rd = ring_t'(ring_q);
  assign qxx     = ring_rd.x * ring_rd.x;
  assign qyy     = ring_rd.y * ring_rd.y;
  assign qxy     = ring_rd.x * ring_rd.y;

  // correlation unit
  always_comb begin
    cin.n          = n_r;
    cin.sum_x      = sum_x_r;
    cin.sum_y      = sum_y_r;
    cin.sum_xx     = sum_xx_r;
    cin.sum_yy     = sum_yy_r;
    cin.sum_xy     = sum_xy_r;
    cin.min_spread = min_spread;
  end

  mwc_corr u_corr (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (c_start),
    .cin    (cin),
    .done   (c_done),
    .result (c_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    st_nxt  = st_r;
    w_pop   = 1'b0;
    ram_we  = 1'b0;
    c_start = 1'b0;
    r_push  = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!w_empty) begin
          w_pop  = 1'b1;
          st_nxt = (fill_r >= WIN_W'(MAX_WINDOW)) ? B_CSTART : B_ADD;
        end
      end
      B_ADD: begin
        ram_we = 1'b1;
        st_nxt = B_LOOP;
      end
      B_LOOP: begin
        if (emit_ok) begin
          st_nxt = B_CSTART;
        end else if (item_r.last) begin
          st_nxt = B_CLEAR;
        end else begin
          st_nxt = B_IDLE;
        end
      end
      B_CSTART: begin
        c_start = 1'b1;
        st_nxt  = B_CWAIT;
      end
      B_CWAIT: begin
        if (c_done) begin
          st_nxt = B_PUSH;
        end
      end
      B_PUSH: begin
        if (!r_full) begin
          r_push = 1'b1;
          st_nxt = B_POP;
        end
      end
      B_POP:   st_nxt = B_UPD;
      B_UPD:   st_nxt = first_r ? B_ADD : B_LOOP;
      B_CLEAR: st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  assign r_data = res_r;

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_xx_r <= '0;
      sum_yy_r <= '0;
      sum_xy_r <= '0;
      n_r      <= '0;
      fill_r   <= '0;
      head_r   <= '0;
      pos_r    <= POS_W'(1);
      k_r      <= '0;
      first_r  <= 1'b0;
      elast_r  <= 1'b0;
    end else begin
      case (st_r)
        B_IDLE: begin
          if (!w_empty) begin
            k_r     <= '0;
            first_r <= (fill_r >= WIN_W'(MAX_WINDOW));
            elast_r <= 1'b0;
          end
        end
        B_ADD: begin
          // samples are sign-extended before the mask is applied
          sum_x_r  <= sum_x_r + (item_r.v ? SUM_X_W'(item_r.x) : '0);
          sum_y_r  <= sum_y_r + (item_r.v ? SUM_X_W'(item_r.y) : '0);
          sum_xx_r <= sum_xx_r + {5'b0, item_r.xx};
          sum_yy_r <= sum_yy_r + {5'b0, item_r.yy};
          sum_xy_r <= sum_xy_r + SUM_XY_W'(item_r.xy);
          if (item_r.v) begin
            n_r <= n_r + 1'b1;
          end
          fill_r  <= fill_r + 1'b1;
          first_r <= 1'b0;
        end
        B_LOOP: begin
          elast_r <= item_r.last && (fill_r == WIN_W'(1));
        end
        B_UPD: begin
          if (rv_r) begin
            sum_x_r  <= sum_x_r - SUM_X_W'(rx_r);
            sum_y_r  <= sum_y_r - SUM_X_W'(ry_r);
            sum_xx_r <= sum_xx_r - {5'b0, rxx_r};
            sum_yy_r <= sum_yy_r - {5'b0, ryy_r};
            sum_xy_r <= sum_xy_r - SUM_XY_W'(rxy_r);
            n_r      <= n_r - 1'b1;
          end
          head_r <= head_r + 1'b1;
          fill_r <= fill_r - 1'b1;
          k_r    <= k_r + 1'b1;
          if (pos_r != POS_MAX) begin
            pos_r <= pos_r + 1'b1;
          end
        end
        B_CLEAR: begin
          sum_x_r  <= '0;
          sum_y_r  <= '0;
          sum_xx_r <= '0;
          sum_yy_r <= '0;
          sum_xy_r <= '0;
          n_r      <= '0;
          fill_r   <= '0;
          head_r   <= '0;
          pos_r    <= POS_W'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && !w_empty) begin
      item_r <= w_data;
    end
    if (st_r == B_CWAIT && c_done) begin
      res_r.position    <= pos_r;
      res_r.correlation <= c_res;
      res_r.valid_count <= n_r;
      res_r.last_result <= elast_r;
    end
    // oldest pair and its products, ready for retirement
    if (st_r == B_POP) begin
      rv_r  <= ring_rd.v;
      rx_r  <= ring_rd.x;
      ry_r  <= ring_rd.y;
      rxx_r <= qxx[SQ_W-1:0];
      ryy_r <= qyy[SQ_W-1:0];
      rxy_r <= qxy;
    end
  end

endmodule

### rtl/masked_window_correlation_top.sv
// ----------------------------------------------------------------------------
// masked_window_correlation_top: masked sliding-window Pearson correlator
// Pair beats in, one Q1.14 coefficient per forward window out.
// ----------------------------------------------------------------------------
// A pair that completes no window is popped, written to the ring and added
// to the sums before the next is taken. A window of masked pairs only yields
// zero; otherwise the coefficient goes through a shared 32x32 multiplier
// that builds the spread and covariance products from limbs and, if the
// spread test passes, runs a bit search of up to 15 steps, each a square and
// a three-limb product. A pair marked last flushes all trailing windows, one
// pass per result. Input pairs queue ahead of the engine and results behind
// it, so a stall on either side is absorbed until that queue fills.
module masked_window_correlation_top #(
  parameter int WORK_DEPTH = mwc_pkg::WORK_DEPTH,
  parameter int OUT_DEPTH  = mwc_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  mwc_pkg::in_t                in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output mwc_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [mwc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mwc_pkg::CFG_W-1:0]   cfg_wdata
);
  import mwc_pkg::*;

  logic [WIN_W-1:0] win_size_r;
  logic [MS_W-1:0]  min_spread_r;
  logic             w_empty, w_pop, r_full, r_push;
  work_t            w_data;
  out_t             r_data;
  logic [$bits(out_t)-1:0] oq_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r   <= WIN_RESET;
      min_spread_r <= MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_SIZE: win_size_r   <= cfg_wdata[WIN_W-1:0];
        REG_MIN_SPREAD:  min_spread_r <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  mwc_front #(
    .DEPTH (WORK_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .w_pop   (w_pop),
    .w_empty (w_empty),
    .w_data  (w_data)
  );

  mwc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_size   (win_size_r),
    .min_spread (min_spread_r),
    .w_empty    (w_empty),
    .w_pop      (w_pop),
    .w_data     (w_data),
    .r_full     (r_full),
    .r_push     (r_push),
    .r_data     (r_data)
  );

  // result queue
  mwc_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .full  (r_full),
    .wdata (r_data),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (oq_rd)
  );

  assign out_data = out_t'(oq_rd);

endmodule
